@@ hw/rtl/sh24_pkg.sv @@
// Shared types, constants and the SipRound function of the SipHash-2-4 block.
package sh24_pkg;

	localparam logic [63:0] INIT_V0 = 64'h736f6d6570736575;
	localparam logic [63:0] INIT_V1 = 64'h646f72616e646f6d;
	localparam logic [63:0] INIT_V2 = 64'h6c7967656e657261;
	localparam logic [63:0] INIT_V3 = 64'h7465646279746573;
	localparam logic [63:0] FIN_XOR = 64'h00000000000000ff;

	localparam int unsigned LEN_SHIFT  = 56;
	localparam int unsigned ABS_ROUNDS = 2;
	localparam int unsigned FIN_ROUNDS = 6;
	localparam logic [3:0]  FULL_BYTES = 4'd8;

	localparam logic REG_KEY_LOW  = 1'b0;
	localparam logic REG_KEY_HIGH = 1'b1;

	typedef struct packed {
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
	} sh24_lanes_t;

	// one block for the round unit
	typedef struct packed {
		logic [63:0] m;
		logic        start;
		logic        fin;
	} sh24_op_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} sh24_qstat_t;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned s);
		rotl = (x << s) | (x >> (64 - s));
	endfunction

	function automatic sh24_lanes_t sip_round(input sh24_lanes_t vi);
		sh24_lanes_t v;
		v = vi;
		v.v0 = v.v0 + v.v1; v.v1 = rotl(v.v1, 13); v.v1 = v.v1 ^ v.v0;
		v.v0 = rotl(v.v0, 32);
		v.v2 = v.v2 + v.v3; v.v3 = rotl(v.v3, 16); v.v3 = v.v3 ^ v.v2;
		v.v0 = v.v0 + v.v3; v.v3 = rotl(v.v3, 21); v.v3 = v.v3 ^ v.v0;
		v.v2 = v.v2 + v.v1; v.v1 = rotl(v.v1, 17); v.v1 = v.v1 ^ v.v2;
		v.v2 = rotl(v.v2, 32);
		return v;
	endfunction

endpackage

@@ hw/rtl/siphash_2_4_hash.sv @@
// Top level of the streaming SipHash-2-4 hash block.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    message_word, byte_count, last
//  out      output     out_valid / out_stall  hash_value
//  config   input      wr_en                  wr_index, wr_data
//
// A word takes two SipRounds in the round unit, one per cycle unless held; the
// next word is taken on its last round. A short last word costs six rounds; a last
// word of eight bytes costs two plus six. The hash is registered on its last round.
// Reset clears the key registers, the queue and all control state.
// Input stalls while the queue is full or a length-only block is still to be queued;
// a stalled hash holds the round unit on its final round only.
module siphash_2_4_hash import sh24_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] message_word,
	input  logic [3:0]  byte_count,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_value,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [63:0] wr_data
);

	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic        push;
	logic        pop;
	sh24_op_t    push_op;
	sh24_op_t    head;
	sh24_qstat_t qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= 64'd0;
			key_high_q <= 64'd0;
		end else if (wr_en) begin
			case (wr_index)
				REG_KEY_LOW:  key_low_q  <= wr_data;
				REG_KEY_HIGH: key_high_q <= wr_data;
				default: ;
			endcase
		end
	end

	sh24_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.message_word (message_word),
		.byte_count   (byte_count),
		.last         (last),
		.qstat        (qstat),
		.push         (push),
		.push_op      (push_op)
	);

	sh24_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	sh24_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_low    (key_low_q),
		.key_high   (key_high_q),
		.head       (head),
		.qstat      (qstat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value)
	);

	a_accept_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !qstat.full)
		else $error("item accepted into a full queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.nonempty)
		else $error("round unit popped an empty queue");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> in_stall)
		else $error("input not stalled while queue is full");

	a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last && (byte_count >= FULL_BYTES)) |=> in_stall)
		else $error("input taken before the length block was queued");

endmodule

@@ hw/rtl/sh24_front.sv @@
// Front end: accepts message words, tracks length and builds blocks for the queue.
module sh24_front import sh24_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] message_word,
	input  logic [3:0]  byte_count,
	input  logic        last,
	input  sh24_qstat_t qstat,
	output logic        push,
	output sh24_op_t    push_op
);

	logic        in_msg_q;
	logic [7:0]  len_q;
	logic        pend_q;
	sh24_op_t    pend_op_q;

	logic        accept;
	logic        start;
	logic [7:0]  base_len;
	logic [3:0]  sat;
	logic        full8;
	logic [63:0] mask;
	logic [7:0]  tail_len;
	sh24_op_t    cur_op;
	sh24_op_t    len_op;

	assign in_stall = pend_q | qstat.full;
	assign accept   = in_valid & ~in_stall;
	assign start    = ~in_msg_q;
	assign base_len = start ? 8'd0 : len_q;
	assign sat      = (byte_count > FULL_BYTES) ? FULL_BYTES : byte_count;
	assign full8    = (sat == FULL_BYTES);
	assign tail_len = base_len + {4'd0, sat};

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			mask[8*i +: 8] = {8{(4'(i) < sat)}};
		end
	end

	always_comb begin
		cur_op.m     = message_word;
		cur_op.start = start;
		cur_op.fin   = 1'b0;
		if (last && !full8) begin
			cur_op.m   = (message_word & mask) | ({56'd0, tail_len} << LEN_SHIFT);
			cur_op.fin = 1'b1;
		end
	end

	// a full last word leaves a length-only final block behind
	always_comb begin
		len_op.m     = {56'd0, base_len + 8'd8} << LEN_SHIFT;
		len_op.start = 1'b0;
		len_op.fin   = 1'b1;
	end

	assign push    = pend_q ? ~qstat.full : accept;
	assign push_op = pend_q ? pend_op_q : cur_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
			len_q    <= 8'd0;
			pend_q   <= 1'b0;
		end else begin
			if (pend_q && !qstat.full) begin
				pend_q <= 1'b0;
			end
			if (accept) begin
				if (!last) begin
					in_msg_q <= 1'b1;
					len_q    <= base_len + 8'd8;
				end else begin
					in_msg_q <= 1'b0;
					if (full8) begin
						pend_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last && full8) begin
			pend_op_q <= len_op;
		end
	end

endmodule

@@ hw/rtl/sh24_queue.sv @@
// Short block queue between the front end and the round unit.
module sh24_queue import sh24_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  sh24_op_t    push_op,
	input  logic        pop,
	output sh24_op_t    head,
	output sh24_qstat_t qstat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	sh24_op_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	logic do_push;
	logic do_pop;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		if (p == PW'(DEPTH - 1)) begin
			return '0;
		end
		return p + PW'(1);
	endfunction

	assign qstat.full     = (cnt_q == CW'(DEPTH));
	assign qstat.nonempty = (cnt_q != '0);
	assign do_push        = push & ~qstat.full;
	assign do_pop         = pop & qstat.nonempty;
	assign head           = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= bump(wr_q);
			end
			if (do_pop) begin
				rd_q <= bump(rd_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_op;
		end
	end

endmodule

@@ hw/rtl/sh24_back.sv @@
// Round unit: one SipRound per cycle unless a stalled hash holds it; absorbs blocks and finalises the hash.
module sh24_back import sh24_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] key_low,
	input  logic [63:0] key_high,
	input  sh24_op_t    head,
	input  sh24_qstat_t qstat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_value
);

	sh24_lanes_t lanes_q;
	sh24_op_t    op_q;
	logic        busy_q;
	logic [2:0]  rnd_q;
	logic        out_valid_q;
	logic [63:0] hash_q;

	logic        last_rnd;
	logic        hold;
	logic        adv;
	sh24_lanes_t rin;
	sh24_lanes_t rout;
	sh24_lanes_t nxt;

	assign last_rnd = op_q.fin ? (rnd_q == 3'(FIN_ROUNDS - 1))
	                           : (rnd_q == 3'(ABS_ROUNDS - 1));
	// hold the final round while the previous hash still waits
	assign hold = op_q.fin & last_rnd & out_valid_q & out_stall;
	assign adv  = busy_q & ~hold;
	assign pop  = qstat.nonempty & (~busy_q | (adv & last_rnd));

	always_comb begin
		rin = lanes_q;
		if (rnd_q == 3'd0) begin
			if (op_q.start) begin
				rin.v0 = INIT_V0 ^ key_low;
				rin.v1 = INIT_V1 ^ key_high;
				rin.v2 = INIT_V2 ^ key_low;
				rin.v3 = INIT_V3 ^ key_high;
			end
			rin.v3 = rin.v3 ^ op_q.m;
		end
	end

	assign rout = sip_round(rin);

	always_comb begin
		nxt = rout;
		if (rnd_q == 3'(ABS_ROUNDS - 1)) begin
			nxt.v0 = rout.v0 ^ op_q.m;
			if (op_q.fin) begin
				nxt.v2 = rout.v2 ^ FIN_XOR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rnd_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				rnd_q <= last_rnd ? 3'd0 : rnd_q + 3'd1;
			end
			if (pop) begin
				busy_q <= 1'b1;
			end else if (adv && last_rnd) begin
				busy_q <= 1'b0;
			end
			if (adv && last_rnd && op_q.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lanes_q <= nxt;
		end
		if (pop) begin
			op_q <= head;
		end
		if (adv && last_rnd && op_q.fin) begin
			hash_q <= rout.v0 ^ rout.v1 ^ rout.v2 ^ rout.v3;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

endmodule
